/* src/goto_turn_and_advance_planner_assert.svh */
// Assertion macros used by the planner top module.
`ifndef GOTO_TURN_AND_ADVANCE_PLANNER_ASSERT_SVH
`define GOTO_TURN_AND_ADVANCE_PLANNER_ASSERT_SVH

// same-cycle implication
`define GTAP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("planner check failed");

// next-cycle implication
`define GTAP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("planner check failed");

`endif

/* src/gtap_pkg.sv */
package gtap_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STAGES   = 20;

  localparam int HEADING_W = 19;
  localparam int SPEED_W   = 16;
  localparam int CFG_W     = 16;
  localparam int TURN_W    = 19;
  localparam int DIST_W    = 25;

  localparam int CFRAC = 8;                          // fraction bits of the offsets
  localparam int XW    = COORD_WIDTH + CFRAC + 4;    // x/y datapath, room for gain
  localparam int ZW    = 34;                         // Q30 angle accumulator
  localparam int SH    = 30 - ANGLE_FRAC_BITS;
  localparam int BW    = ZW - SH;                    // bearing width
  localparam int DW    = BW + 2;                     // turn angle before saturation

  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint PI_Q = (64'd3373259426 + (64'd1 << (SH - 1))) >> SH;

  localparam int GAIN_W    = 20;
  localparam int INV_GAIN  = 636751;                 // 1/K in Q20
  localparam int XU        = XW - 1;                 // magnitude bits of x
  localparam int LO_W      = (XU + 1) / 2;
  localparam int HI_W      = XU - LO_W;
  localparam int P_LO_W    = LO_W + GAIN_W;
  localparam int P_HI_W    = HI_W + GAIN_W;
  localparam int SCALED_W  = XU + GAIN_W;
  localparam int DIST_FRAC = CFRAC + GAIN_W;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    DIR_ADVANCE = 2'd0,
    DIR_CCW     = 2'd1,
    DIR_CW      = 2'd2
  } dir_t;

  typedef enum logic {
    REG_TURN_DEADBAND = 1'b0,
    REG_MIN_DISTANCE  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                        valid;
    logic                        zero;
    logic signed [XW-1:0]        x;
    logic signed [XW-1:0]        y;
    logic signed [ZW-1:0]        z;
    logic signed [HEADING_W-1:0] heading;
    logic [SPEED_W-1:0]          speed;
  } vec_t;

  typedef struct packed {
    logic                     valid;
    logic                     do_turn;
    logic                     do_adv;
    dir_t                     dir;
    logic signed [TURN_W-1:0] angle;
    logic [DIST_W-1:0]        travel;
    logic [SPEED_W-1:0]       speed;
  } plan_t;

endpackage

/* src/goto_turn_and_advance_planner.sv */
// Go-to planner: takes a target point, current position/heading and speed,
// and emits up to two move words: a turn (if |turn angle| > turn_deadband),
// then a forward advance (if twice the distance exceeds min_distance_half_mm,
// compared exactly). Bearing and distance come from a 20-stage pipelined
// vectoring CORDIC. From accept to first word an item passes the input
// register, pre-rotation, 20 CORDIC stages, 3 post stages, output register.
// A new command is taken every cycle while busy is low. busy rises for one
// cycle when an item yields both a turn and an advance, since the output
// port carries one word per cycle; the whole pipeline holds during it.
// Each move word is shown for exactly one cycle with move_strobe high;
// the receiver cannot stall. last_move marks the final word of an item.
// An item that yields no move produces no word.
module goto_turn_and_advance_planner (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 wr_en,
  input  logic                                 wr_index,
  input  logic [gtap_pkg::CFG_W-1:0]           wr_data,
  input  logic signed [gtap_pkg::COORD_WIDTH-1:0] target_x,
  input  logic signed [gtap_pkg::COORD_WIDTH-1:0] target_y,
  input  logic signed [gtap_pkg::COORD_WIDTH-1:0] current_x,
  input  logic signed [gtap_pkg::COORD_WIDTH-1:0] current_y,
  input  logic signed [gtap_pkg::HEADING_W-1:0]   current_heading,
  input  logic [gtap_pkg::SPEED_W-1:0]         speed_limit,
  output logic                                 move_strobe,
  output logic [1:0]                           direction,
  output logic signed [gtap_pkg::TURN_W-1:0]   turn_angle,
  output logic [gtap_pkg::DIST_W-1:0]          advance_mm,
  output logic [gtap_pkg::SPEED_W-1:0]         move_speed,
  output logic                                 last_move
);

  `include "goto_turn_and_advance_planner_assert.svh"

  localparam int OW = gtap_pkg::COORD_WIDTH + 1;   // offset width

  // config registers
  logic [gtap_pkg::CFG_W-1:0] turn_deadband;
  logic [gtap_pkg::CFG_W-1:0] min_distance_half_mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_deadband        <= '0;
      min_distance_half_mm <= gtap_pkg::CFG_W'(1);
    end else if (wr_en) begin
      case (gtap_pkg::reg_idx_t'(wr_index))
        gtap_pkg::REG_TURN_DEADBAND: turn_deadband        <= wr_data;
        gtap_pkg::REG_MIN_DISTANCE:  min_distance_half_mm <= wr_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: held while the second word of an item goes out
  logic pend;
  logic en;
  logic accept;

  assign en     = !pend;
  assign busy   = pend;
  assign accept = start && !pend;

  // stage A: offsets
  logic                                  a_valid;
  logic signed [OW-1:0]                  a_dx, a_dy;
  logic signed [gtap_pkg::HEADING_W-1:0] a_heading;
  logic [gtap_pkg::SPEED_W-1:0]          a_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx      <= OW'(target_x) - OW'(current_x);
      a_dy      <= OW'(target_y) - OW'(current_y);
      a_heading <= current_heading;
      a_speed   <= speed_limit;
    end
  end

  // stage B: scale to 8 fraction bits, fold left half-plane by +-90 deg
  logic signed [gtap_pkg::XW-1:0] x0, y0;
  gtap_pkg::vec_t                 b_nxt, b_vec, cordic_out;

  assign x0 = gtap_pkg::XW'(a_dx) <<< gtap_pkg::CFRAC;
  assign y0 = gtap_pkg::XW'(a_dy) <<< gtap_pkg::CFRAC;

  always_comb begin
    b_nxt.valid   = a_valid;
    b_nxt.zero    = (a_dx == '0) && (a_dy == '0);
    b_nxt.heading = a_heading;
    b_nxt.speed   = a_speed;
    b_nxt.x       = x0;
    b_nxt.y       = y0;
    b_nxt.z       = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        b_nxt.x = y0;
        b_nxt.y = -x0;
        b_nxt.z = gtap_pkg::ZW'(gtap_pkg::HALF_PI_Q30);
      end else begin
        b_nxt.x = -y0;
        b_nxt.y = x0;
        b_nxt.z = -gtap_pkg::ZW'(gtap_pkg::HALF_PI_Q30);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vec.valid <= 1'b0;
    end else if (en) begin
      b_vec <= b_nxt;
    end
  end

  gtap_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (b_vec),
    .dout (cordic_out)
  );

  gtap_pkg::plan_t plan;

  gtap_post u_post (
    .clk                  (clk),
    .rst                  (rst),
    .en                   (en),
    .din                  (cordic_out),
    .turn_deadband        (turn_deadband),
    .min_distance_half_mm (min_distance_half_mm),
    .dout                 (plan)
  );

  // output: turn word first, advance word parked in pend for the next cycle
  logic [gtap_pkg::DIST_W-1:0]  pend_dist;
  logic [gtap_pkg::SPEED_W-1:0] pend_speed;
  logic                         pend_next;
  logic                         strobe_next;
  gtap_pkg::dir_t               dir_next;
  logic signed [gtap_pkg::TURN_W-1:0] angle_next;
  logic [gtap_pkg::DIST_W-1:0]  dist_next;
  logic [gtap_pkg::SPEED_W-1:0] speed_next;
  logic                         last_next;

  always_comb begin
    pend_next   = 1'b0;
    strobe_next = 1'b0;
    dir_next    = gtap_pkg::DIR_ADVANCE;
    angle_next  = '0;
    dist_next   = '0;
    speed_next  = plan.speed;
    last_next   = 1'b1;
    if (pend) begin
      strobe_next = 1'b1;
      dist_next   = pend_dist;
      speed_next  = pend_speed;
    end else if (plan.valid && plan.do_turn) begin
      strobe_next = 1'b1;
      dir_next    = plan.dir;
      angle_next  = plan.angle;
      last_next   = !plan.do_adv;
      pend_next   = plan.do_adv;
    end else if (plan.valid && plan.do_adv) begin
      strobe_next = 1'b1;
      dist_next   = plan.travel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= 1'b0;
      move_strobe <= 1'b0;
    end else begin
      pend        <= pend_next;
      move_strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!pend) begin
      pend_dist  <= plan.travel;
      pend_speed <= plan.speed;
    end
    direction   <= dir_next;
    turn_angle  <= angle_next;
    advance_mm  <= dist_next;
    move_speed  <= speed_next;
    last_move   <= last_next;
  end

  // busy never lasts more than one cycle
  `GTAP_ASSERT_NEXT(a_pend_single, pend, !pend)
  // the parked word goes out as a final advance
  `GTAP_ASSERT_NEXT(a_pend_emits, pend,
    move_strobe && (direction == gtap_pkg::DIR_ADVANCE) && last_move)
  // a turn that is not last is followed at once by its advance
  `GTAP_ASSERT_NEXT(a_turn_then_adv,
    move_strobe && (direction != gtap_pkg::DIR_ADVANCE) && !last_move,
    move_strobe && (direction == gtap_pkg::DIR_ADVANCE) && last_move)
  // an advance word is always the last word of its item
  `GTAP_ASSERT_NOW(a_adv_last,
    move_strobe && (direction == gtap_pkg::DIR_ADVANCE), last_move)

endmodule

/* src/gtap_cordic.sv */
module gtap_cordic (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  gtap_pkg::vec_t din,
  output gtap_pkg::vec_t dout
);

  gtap_pkg::vec_t stg [gtap_pkg::CORDIC_STAGES+1];

  assign stg[0] = din;

  for (genvar i = 0; i < gtap_pkg::CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [gtap_pkg::ZW-1:0] ATAN =
      gtap_pkg::ZW'(gtap_pkg::ATAN_Q30[i]);
    logic signed [gtap_pkg::XW-1:0] xs, ys;
    gtap_pkg::vec_t nxt;

    assign xs = stg[i].x >>> i;
    assign ys = stg[i].y >>> i;

    // rotate toward y = 0
    always_comb begin
      nxt = stg[i];
      if (stg[i].y > 0) begin
        nxt.x = stg[i].x + ys;
        nxt.y = stg[i].y - xs;
        nxt.z = stg[i].z + ATAN;
      end else begin
        nxt.x = stg[i].x - ys;
        nxt.y = stg[i].y + xs;
        nxt.z = stg[i].z - ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[i+1].valid <= 1'b0;
      end else if (en) begin
        stg[i+1] <= nxt;
      end
    end
  end

  assign dout = stg[gtap_pkg::CORDIC_STAGES];

endmodule

/* src/gtap_post.sv */
module gtap_post (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  gtap_pkg::vec_t            din,
  input  logic [gtap_pkg::CFG_W-1:0] turn_deadband,
  input  logic [gtap_pkg::CFG_W-1:0] min_distance_half_mm,
  output gtap_pkg::plan_t           dout
);

  localparam logic signed [gtap_pkg::DW-1:0] PI_D = gtap_pkg::DW'(gtap_pkg::PI_Q);
  localparam logic signed [gtap_pkg::DW-1:0] TURN_MAX =
    gtap_pkg::DW'((64'd1 << (gtap_pkg::TURN_W - 1)) - 64'd1);
  localparam logic signed [gtap_pkg::DW-1:0] TURN_MIN = -TURN_MAX - 1;

  // stage C: bearing rounding, gain partial products
  logic                                 c_valid;
  logic signed [gtap_pkg::BW-1:0]        c_bearing;
  logic signed [gtap_pkg::HEADING_W-1:0] c_heading;
  logic [gtap_pkg::SPEED_W-1:0]          c_speed;
  logic [gtap_pkg::P_LO_W-1:0]           c_plo;
  logic [gtap_pkg::P_HI_W-1:0]           c_phi;

  logic signed [gtap_pkg::ZW-1:0] zr;
  logic [gtap_pkg::XU-1:0]        xu;

  assign zr = din.z + gtap_pkg::ZW'(64'd1 << (gtap_pkg::SH - 1));
  assign xu = din.x[gtap_pkg::XU-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_bearing <= din.zero ? '0 : zr[gtap_pkg::ZW-1:gtap_pkg::SH];
      c_heading <= din.heading;
      c_speed   <= din.speed;
      c_plo     <= gtap_pkg::P_LO_W'(xu[gtap_pkg::LO_W-1:0]) *
                   gtap_pkg::P_LO_W'(gtap_pkg::INV_GAIN);
      c_phi     <= gtap_pkg::P_HI_W'(xu[gtap_pkg::XU-1:gtap_pkg::LO_W]) *
                   gtap_pkg::P_HI_W'(gtap_pkg::INV_GAIN);
    end
  end

  // stage D: turn angle with one wrap, product sum
  logic                            d_valid;
  logic signed [gtap_pkg::DW-1:0]  d_delta;
  logic [gtap_pkg::SPEED_W-1:0]    d_speed;
  logic [gtap_pkg::SCALED_W-1:0]   d_scaled;

  logic signed [gtap_pkg::DW-1:0] delta;

  assign delta = gtap_pkg::DW'(c_bearing) - gtap_pkg::DW'(c_heading);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (delta > PI_D) begin
        d_delta <= delta - (PI_D <<< 1);
      end else if (delta < -PI_D) begin
        d_delta <= delta + (PI_D <<< 1);
      end else begin
        d_delta <= delta;
      end
      d_speed  <= c_speed;
      d_scaled <= {c_phi, {gtap_pkg::LO_W{1'b0}}} + gtap_pkg::SCALED_W'(c_plo);
    end
  end

  // stage E: saturate, move decisions
  logic signed [gtap_pkg::DW-1:0] sat;
  logic [gtap_pkg::DW-1:0]        mag;
  logic [gtap_pkg::SCALED_W-gtap_pkg::DIST_FRAC-1:0] dist_full;
  logic [gtap_pkg::SCALED_W-1:0]  adv_thresh;
  gtap_pkg::plan_t                nxt;

  assign dist_full  = d_scaled[gtap_pkg::SCALED_W-1:gtap_pkg::DIST_FRAC];
  assign adv_thresh = gtap_pkg::SCALED_W'(min_distance_half_mm) << (gtap_pkg::DIST_FRAC - 1);

  always_comb begin
    if (d_delta > TURN_MAX) begin
      sat = TURN_MAX;
    end else if (d_delta < TURN_MIN) begin
      sat = TURN_MIN;
    end else begin
      sat = d_delta;
    end
    mag         = sat[gtap_pkg::DW-1] ? gtap_pkg::DW'(-sat) : gtap_pkg::DW'(sat);
    nxt.valid   = d_valid;
    nxt.do_turn = mag > gtap_pkg::DW'(turn_deadband);
    nxt.do_adv  = d_scaled > adv_thresh;
    nxt.dir     = sat[gtap_pkg::DW-1] ? gtap_pkg::DIR_CW : gtap_pkg::DIR_CCW;
    nxt.angle   = sat[gtap_pkg::TURN_W-1:0];
    if (dist_full > (gtap_pkg::SCALED_W - gtap_pkg::DIST_FRAC)'(
          (64'd1 << gtap_pkg::DIST_W) - 64'd1)) begin
      nxt.travel = '1;
    end else begin
      nxt.travel = dist_full[gtap_pkg::DIST_W-1:0];
    end
    nxt.speed = d_speed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule
